@@ hdl/swbt_pkg.sv @@
// ----------------------------------------------------------------------------
// swbt_pkg: shared types and constants of the segment wall block test
// Register codes, configuration record, hit kinds and slab status flags.
// ----------------------------------------------------------------------------
package swbt_pkg;

  // APB register map
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // fixed field widths
  localparam int unsigned UDIR_W = 16;
  localparam int unsigned HALF_W = 23;
  localparam int unsigned TOL_W  = 8;

  // disc test: magnitudes at or above 2^DISC_MAG_BITS are never inside
  localparam int unsigned DISC_MAG_BITS = 24;
  localparam int unsigned SQ_W          = 2 * DISC_MAG_BITS;
  localparam int unsigned LIM_W         = 2 * HALF_W + 1;

  typedef enum logic [2:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_UNIT_DIR_X     = 3'd2,
    REG_UNIT_DIR_Y     = 3'd3,
    REG_HALF_LENGTH    = 3'd4,
    REG_HALF_THICKNESS = 3'd5,
    REG_TOLERANCE      = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSIDE = 2'd1,
    KIND_CROSS  = 2'd2
  } hit_kind_e;

  // wall shape registers (centers travel separately, their width varies)
  typedef struct packed {
    logic signed [UDIR_W-1:0] unit_dir_x;
    logic signed [UDIR_W-1:0] unit_dir_y;
    logic [HALF_W-1:0]        half_length;
    logic [HALF_W-1:0]        half_thickness;
    logic [TOL_W-1:0]         tolerance;
  } cfg_t;

  // decision status handed from the classify stage to the slab stages
  typedef struct packed {
    logic kind_inside;  // an endpoint lies inside the wall
    logic slab_pend;    // no early decision, slab test decides
    logic slab_pre_ok;  // per-axis checks against t = 0 and t = 1 pass
    logic need_cross;   // both slabs active, cross products decide
  } flags_t;

endpackage

@@ hdl/swbt_if.sv @@
// ----------------------------------------------------------------------------
// swbt interfaces: valid/ready channels of the segment wall block test
// Point pair channel in, result channel out.
// ----------------------------------------------------------------------------
interface swbt_in_if #(
  parameter int unsigned COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] receiver_x;
  logic signed [COORD_WIDTH-1:0] receiver_y;
  logic signed [COORD_WIDTH-1:0] emitter_pos_x;
  logic signed [COORD_WIDTH-1:0] emitter_pos_y;

  modport source (output valid, receiver_x, receiver_y, emitter_pos_x, emitter_pos_y,
                  input ready);
  modport sink   (input valid, receiver_x, receiver_y, emitter_pos_x, emitter_pos_y,
                  output ready);
endinterface

interface swbt_out_if;
  logic       valid;
  logic       ready;
  logic       blocked;
  logic [1:0] hit_kind;

  modport source (output valid, blocked, hit_kind, input ready);
  modport sink   (input valid, blocked, hit_kind, output ready);
endinterface

@@ hdl/swbt_regs.sv @@
// ----------------------------------------------------------------------------
// swbt_regs: APB configuration registers
// Seven wall registers, written on the APB access cycle, read back as stored.
// ----------------------------------------------------------------------------
module swbt_regs
  import swbt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  output logic signed [COORD_WIDTH-1:0] center_x_o,
  output logic signed [COORD_WIDTH-1:0] center_y_o,
  output cfg_t                          cfg_o
);

  logic signed [COORD_WIDTH-1:0] center_x_q, center_y_q;
  cfg_t                          cfg_q;
  reg_idx_e                      idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q           <= '0;
      center_y_q           <= '0;
      cfg_q.unit_dir_x     <= UDIR_W'(16384);
      cfg_q.unit_dir_y     <= '0;
      cfg_q.half_length    <= '0;
      cfg_q.half_thickness <= '0;
      cfg_q.tolerance      <= TOL_W'(1);
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_CENTER_X:       center_x_q           <= pwdata[COORD_WIDTH-1:0];
        REG_CENTER_Y:       center_y_q           <= pwdata[COORD_WIDTH-1:0];
        REG_UNIT_DIR_X:     cfg_q.unit_dir_x     <= pwdata[UDIR_W-1:0];
        REG_UNIT_DIR_Y:     cfg_q.unit_dir_y     <= pwdata[UDIR_W-1:0];
        REG_HALF_LENGTH:    cfg_q.half_length    <= pwdata[HALF_W-1:0];
        REG_HALF_THICKNESS: cfg_q.half_thickness <= pwdata[HALF_W-1:0];
        REG_TOLERANCE:      cfg_q.tolerance      <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_CENTER_X:       prdata = APB_DATA_W'(center_x_q);
      REG_CENTER_Y:       prdata = APB_DATA_W'(center_y_q);
      REG_UNIT_DIR_X:     prdata = APB_DATA_W'(cfg_q.unit_dir_x);
      REG_UNIT_DIR_Y:     prdata = APB_DATA_W'(cfg_q.unit_dir_y);
      REG_HALF_LENGTH:    prdata = APB_DATA_W'(cfg_q.half_length);
      REG_HALF_THICKNESS: prdata = APB_DATA_W'(cfg_q.half_thickness);
      REG_TOLERANCE:      prdata = APB_DATA_W'(cfg_q.tolerance);
      default:            prdata = '0;
    endcase
  end

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;
  assign cfg_o      = cfg_q;

endmodule

@@ hdl/swbt_proj.sv @@
// ----------------------------------------------------------------------------
// swbt_proj: wall frame projection, three stages
// Offsets from the center, direction products and squares, then the axial
// and perpendicular sums and the disc inside test.
// ----------------------------------------------------------------------------
module swbt_proj
  import swbt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned UNIT_FRAC_BITS = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       rx_i,
  input  logic signed [COORD_WIDTH-1:0]       ry_i,
  input  logic signed [COORD_WIDTH-1:0]       ex_i,
  input  logic signed [COORD_WIDTH-1:0]       ey_i,
  input  logic signed [COORD_WIDTH-1:0]       cx_i,
  input  logic signed [COORD_WIDTH-1:0]       cy_i,
  input  cfg_t                                cfg_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [COORD_WIDTH+UDIR_W+1:0] ra_o,
  output logic signed [COORD_WIDTH+UDIR_W+1:0] rp_o,
  output logic signed [COORD_WIDTH+UDIR_W+1:0] ea_o,
  output logic signed [COORD_WIDTH+UDIR_W+1:0] ep_o,
  output logic                                disc_in_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;  // offset
  localparam int unsigned MW = DW + UDIR_W;      // one product
  localparam int unsigned PW = MW + 1;           // projection sum
  localparam int unsigned NS = 3;

  // stage handshake: a stage loads when it is empty or the next one moves
  logic [NS-1:0] v_q, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 1: offsets from the wall center
  logic signed [DW-1:0] rdx_q, rdy_q, edx_q, edy_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rdx_q <= DW'(rx_i) - DW'(cx_i);
      rdy_q <= DW'(ry_i) - DW'(cy_i);
      edx_q <= DW'(ex_i) - DW'(cx_i);
      edy_q <= DW'(ey_i) - DW'(cy_i);
    end
  end

  // stage 2: direction products, squared magnitudes for the disc case
  logic [DW-1:0]            rmx, rmy, emx, emy;
  logic signed [MW-1:0]     r_xux_q, r_yuy_q, r_yux_q, r_xuy_q;
  logic signed [MW-1:0]     e_xux_q, e_yuy_q, e_yux_q, e_xuy_q;
  logic [SQ_W-1:0]          rsx_q, rsy_q, esx_q, esy_q;
  logic                     r_ovf_q, e_ovf_q;
  logic [2*HALF_W-1:0]      ht_sq_q;

  assign rmx = rdx_q[DW-1] ? DW'(-rdx_q) : DW'(rdx_q);
  assign rmy = rdy_q[DW-1] ? DW'(-rdy_q) : DW'(rdy_q);
  assign emx = edx_q[DW-1] ? DW'(-edx_q) : DW'(edx_q);
  assign emy = edy_q[DW-1] ? DW'(-edy_q) : DW'(edy_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      r_xux_q <= MW'(rdx_q) * MW'(cfg_i.unit_dir_x);
      r_yuy_q <= MW'(rdy_q) * MW'(cfg_i.unit_dir_y);
      r_yux_q <= MW'(rdy_q) * MW'(cfg_i.unit_dir_x);
      r_xuy_q <= MW'(rdx_q) * MW'(cfg_i.unit_dir_y);
      e_xux_q <= MW'(edx_q) * MW'(cfg_i.unit_dir_x);
      e_yuy_q <= MW'(edy_q) * MW'(cfg_i.unit_dir_y);
      e_yux_q <= MW'(edy_q) * MW'(cfg_i.unit_dir_x);
      e_xuy_q <= MW'(edx_q) * MW'(cfg_i.unit_dir_y);
      rsx_q   <= SQ_W'(DISC_MAG_BITS'(rmx)) * SQ_W'(DISC_MAG_BITS'(rmx));
      rsy_q   <= SQ_W'(DISC_MAG_BITS'(rmy)) * SQ_W'(DISC_MAG_BITS'(rmy));
      esx_q   <= SQ_W'(DISC_MAG_BITS'(emx)) * SQ_W'(DISC_MAG_BITS'(emx));
      esy_q   <= SQ_W'(DISC_MAG_BITS'(emy)) * SQ_W'(DISC_MAG_BITS'(emy));
      r_ovf_q <= ((rmx >> DISC_MAG_BITS) != '0) || ((rmy >> DISC_MAG_BITS) != '0);
      e_ovf_q <= ((emx >> DISC_MAG_BITS) != '0) || ((emy >> DISC_MAG_BITS) != '0);
      ht_sq_q <= (2*HALF_W)'(cfg_i.half_thickness) * (2*HALF_W)'(cfg_i.half_thickness);
    end
  end

  // stage 3: projections and disc inside test
  logic [LIM_W-1:0]        lim;
  logic                    r_disc, e_disc;
  logic signed [PW-1:0]    ra_q, rp_q, ea_q, ep_q;
  logic                    disc_in_q;

  assign lim    = LIM_W'(ht_sq_q) + LIM_W'(cfg_i.tolerance);
  assign r_disc = !r_ovf_q && ((SQ_W + 1)'(rsx_q) + (SQ_W + 1)'(rsy_q) <= (SQ_W + 1)'(lim));
  assign e_disc = !e_ovf_q && ((SQ_W + 1)'(esx_q) + (SQ_W + 1)'(esy_q) <= (SQ_W + 1)'(lim));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ra_q      <= PW'(r_xux_q) + PW'(r_yuy_q);
      rp_q      <= PW'(r_yux_q) - PW'(r_xuy_q);
      ea_q      <= PW'(e_xux_q) + PW'(e_yuy_q);
      ep_q      <= PW'(e_yux_q) - PW'(e_xuy_q);
      disc_in_q <= r_disc || e_disc;
    end
  end

  assign ra_o      = ra_q;
  assign rp_o      = rp_q;
  assign ea_o      = ea_q;
  assign ep_o      = ep_q;
  assign disc_in_o = disc_in_q;

endmodule

@@ hdl/swbt_clas.sv @@
// ----------------------------------------------------------------------------
// swbt_clas: classify stage
// Box inside test, box reject, slab setup (entry/exit fractions) and the
// checks of each slab against t = 0 and t = 1.
// ----------------------------------------------------------------------------
module swbt_clas
  import swbt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned UNIT_FRAC_BITS = 14,
  localparam int unsigned PW            = COORD_WIDTH + UDIR_W + 2,
  localparam int unsigned BW            = HALF_W + 2 + UNIT_FRAC_BITS,
  localparam int unsigned SlabW         = ((PW > BW) ? PW : BW) + 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH+UDIR_W+1:0] ra_i,
  input  logic signed [COORD_WIDTH+UDIR_W+1:0] rp_i,
  input  logic signed [COORD_WIDTH+UDIR_W+1:0] ea_i,
  input  logic signed [COORD_WIDTH+UDIR_W+1:0] ep_i,
  input  logic                                 disc_in_i,
  input  cfg_t                                 cfg_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SlabW-1:0]              lo_a_o,
  output logic signed [SlabW-1:0]              hi_a_o,
  output logic signed [SlabW-1:0]              den_a_o,
  output logic signed [SlabW-1:0]              lo_p_o,
  output logic signed [SlabW-1:0]              hi_p_o,
  output logic signed [SlabW-1:0]              den_p_o,
  output flags_t                               flags_o
);

  // single stage handshake
  logic v_q, en;

  assign en          = !v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  // bounds at projection scale
  logic signed [SlabW-1:0] b_a, b_p, tol, bt_a, bt_p;
  logic signed [SlabW-1:0] ea, ra, ep, rp;

  assign b_a  = $signed(SlabW'(cfg_i.half_length) << UNIT_FRAC_BITS);
  assign b_p  = $signed(SlabW'(cfg_i.half_thickness) << UNIT_FRAC_BITS);
  assign tol  = $signed(SlabW'(cfg_i.tolerance) << UNIT_FRAC_BITS);
  assign bt_a = b_a + tol;
  assign bt_p = b_p + tol;
  assign ea   = SlabW'(ea_i);
  assign ra   = SlabW'(ra_i);
  assign ep   = SlabW'(ep_i);
  assign rp   = SlabW'(rp_i);

  // endpoints inside the widened box
  logic r_in, e_in;

  assign r_in = (ra <= bt_a) && (ra >= -bt_a) && (rp <= bt_p) && (rp >= -bt_p);
  assign e_in = (ea <= bt_a) && (ea >= -bt_a) && (ep <= bt_p) && (ep >= -bt_p);

  // box reject on each axis
  logic signed [SlabW-1:0] mn_a, mx_a, mn_p, mx_p;
  logic                    rej;

  assign mn_a = (ea < ra) ? ea : ra;
  assign mx_a = (ea < ra) ? ra : ea;
  assign mn_p = (ep < rp) ? ep : rp;
  assign mx_p = (ep < rp) ? rp : ep;
  assign rej  = (mx_a < -bt_a) || (mn_a > bt_a) || (mx_p < -bt_p) || (mn_p > bt_p);

  // slab setup: fractions lo/den (entry) and hi/den (exit), den > 0 unless the slab is skipped
  logic signed [SlabW-1:0] d_a, d_p, den_a_d, den_p_d, lo_a_d, hi_a_d, lo_p_d, hi_p_d;
  logic                    skip_a, skip_p, ok_a, ok_p;

  assign d_a     = ra - ea;
  assign d_p     = rp - ep;
  assign skip_a  = (d_a <= tol) && (d_a >= -tol);
  assign skip_p  = (d_p <= tol) && (d_p >= -tol);
  assign den_a_d = (d_a > 0) ? d_a : -d_a;
  assign den_p_d = (d_p > 0) ? d_p : -d_p;
  assign lo_a_d  = (d_a > 0) ? (-b_a - ea) : (ea - b_a);
  assign hi_a_d  = (d_a > 0) ? (b_a - ea) : (ea + b_a);
  assign lo_p_d  = (d_p > 0) ? (-b_p - ep) : (ep - b_p);
  assign hi_p_d  = (d_p > 0) ? (b_p - ep) : (ep + b_p);
  // exit not before t = 0, entry not after t = 1
  assign ok_a    = skip_a || ((hi_a_d >= 0) && (lo_a_d <= den_a_d));
  assign ok_p    = skip_p || ((hi_p_d >= 0) && (lo_p_d <= den_p_d));

  flags_t flags_d;

  always_comb begin
    flags_d.kind_inside = (cfg_i.half_length == '0) ? disc_in_i : (r_in || e_in);
    flags_d.slab_pend   = (cfg_i.half_length != '0) && !r_in && !e_in && !rej;
    flags_d.slab_pre_ok = ok_a && ok_p;
    flags_d.need_cross  = !skip_a && !skip_p;
  end

  logic signed [SlabW-1:0] lo_a_q, hi_a_q, den_a_q, lo_p_q, hi_p_q, den_p_q;
  flags_t                  flags_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_a_q  <= lo_a_d;
      hi_a_q  <= hi_a_d;
      den_a_q <= den_a_d;
      lo_p_q  <= lo_p_d;
      hi_p_q  <= hi_p_d;
      den_p_q <= den_p_d;
      flags_q <= flags_d;
    end
  end

  assign lo_a_o  = lo_a_q;
  assign hi_a_o  = hi_a_q;
  assign den_a_o = den_a_q;
  assign lo_p_o  = lo_p_q;
  assign hi_p_o  = hi_p_q;
  assign den_p_o = den_p_q;
  assign flags_o = flags_q;

endmodule

@@ hdl/swbt_slab.sv @@
// ----------------------------------------------------------------------------
// swbt_slab: cross-slab fraction compare, three stages
// Entry of one slab against exit of the other by cross products, each cut
// into four half-width partial products; the last stage holds the result.
// ----------------------------------------------------------------------------
module swbt_slab
  import swbt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned UNIT_FRAC_BITS = 14,
  localparam int unsigned PW            = COORD_WIDTH + UDIR_W + 2,
  localparam int unsigned BW            = HALF_W + 2 + UNIT_FRAC_BITS,
  localparam int unsigned SlabW         = ((PW > BW) ? PW : BW) + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [SlabW-1:0] lo_a_i,
  input  logic signed [SlabW-1:0] hi_a_i,
  input  logic signed [SlabW-1:0] den_a_i,
  input  logic signed [SlabW-1:0] lo_p_i,
  input  logic signed [SlabW-1:0] hi_p_i,
  input  logic signed [SlabW-1:0] den_p_i,
  input  flags_t                  flags_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    blocked_o,
  output logic [1:0]              hit_kind_o
);

  localparam int unsigned HB    = (SlabW + 1) / 2;     // low part, unsigned
  localparam int unsigned HH    = SlabW - HB;          // high part, signed
  localparam int unsigned HHW   = 2 * HH;
  localparam int unsigned HLW   = HH + HB + 1;
  localparam int unsigned LLW   = 2 * HB + 2;
  localparam int unsigned FW    = 2 * SlabW;
  localparam int unsigned NS    = 3;

  typedef struct packed {
    logic signed [HHW-1:0] hh;
    logic signed [HLW-1:0] hl;
    logic signed [HLW-1:0] lh;
    logic signed [LLW-1:0] ll;
  } pp_t;

  // partial products of x*y
  function automatic pp_t part_mul(logic signed [SlabW-1:0] x, logic signed [SlabW-1:0] y);
    logic signed [HH-1:0] xh, yh;
    logic signed [HB:0]   xl, yl;
    pp_t                  r;
    xh   = x[SlabW-1:HB];
    yh   = y[SlabW-1:HB];
    xl   = $signed({1'b0, x[HB-1:0]});
    yl   = $signed({1'b0, y[HB-1:0]});
    r.hh = HHW'(xh) * HHW'(yh);
    r.hl = HLW'(xh) * HLW'(yl);
    r.lh = HLW'(xl) * HLW'(yh);
    r.ll = LLW'(xl) * LLW'(yl);
    return r;
  endfunction

  function automatic logic signed [FW-1:0] part_sum(pp_t p);
    return (FW'(p.hh) <<< (2 * HB)) + (FW'(p.hl) <<< HB) + (FW'(p.lh) <<< HB) + FW'(p.ll);
  endfunction

  // stage handshake
  logic [NS-1:0] v_q, en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  // stage 1: partial products
  // entry a vs exit p: lo_a*den_p <= hi_p*den_a; entry p vs exit a likewise
  pp_t    p1_q, p2_q, p3_q, p4_q;
  flags_t f1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p1_q <= part_mul(lo_a_i, den_p_i);
      p2_q <= part_mul(hi_p_i, den_a_i);
      p3_q <= part_mul(lo_p_i, den_a_i);
      p4_q <= part_mul(hi_a_i, den_p_i);
      f1_q <= flags_i;
    end
  end

  // stage 2: full products
  logic signed [FW-1:0] q1_q, q2_q, q3_q, q4_q;
  flags_t               f2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      q1_q <= part_sum(p1_q);
      q2_q <= part_sum(p2_q);
      q3_q <= part_sum(p3_q);
      q4_q <= part_sum(p4_q);
      f2_q <= f1_q;
    end
  end

  // stage 3: compare and result word
  logic      cross_ok, crosses;
  hit_kind_e kind_d, kind_q;

  assign cross_ok = !f2_q.need_cross || ((q1_q <= q2_q) && (q3_q <= q4_q));
  assign crosses  = f2_q.slab_pend && f2_q.slab_pre_ok && cross_ok;

  always_comb begin
    priority if (f2_q.kind_inside) begin
      kind_d = KIND_INSIDE;
    end else if (crosses) begin
      kind_d = KIND_CROSS;
    end else begin
      kind_d = KIND_CLEAR;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      kind_q <= kind_d;
    end
  end

  assign hit_kind_o = kind_q;
  assign blocked_o  = (kind_q != KIND_CLEAR);

endmodule

@@ hdl/segment_wall_block_test.sv @@
// ----------------------------------------------------------------------------
// segment_wall_block_test: segment versus thick wall blocking test
// Tells whether a wall held in registers blocks the emitter-receiver segment.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  item_i    in   valid/ready      receiver_x/y, emitter_pos_x/y
//  result_o  out  valid/ready      blocked, hit_kind
//  apb       in   psel/penable     wall registers at byte address 4*index
//
//  One word enters per cycle unless the result channel stalls. There are
//  three projection, one classify and three slab compare stages; the rate
//  is set by the stage pipeline: every stage loads whenever it is empty or
//  its successor moves, so a stalled result holds and bubbles are squeezed
//  out. Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module segment_wall_block_test
  import swbt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH    = 24,
  parameter int unsigned UNIT_FRAC_BITS = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swbt_in_if.sink               item_i,
  swbt_out_if.source            result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PW    = COORD_WIDTH + UDIR_W + 2;
  localparam int unsigned BW    = HALF_W + 2 + UNIT_FRAC_BITS;
  localparam int unsigned SlabW = ((PW > BW) ? PW : BW) + 2;

  logic signed [COORD_WIDTH-1:0] center_x, center_y;
  cfg_t                          cfg;

  // configuration registers
  swbt_regs #(.COORD_WIDTH(COORD_WIDTH)) u_regs (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .center_x_o (center_x),
    .center_y_o (center_y),
    .cfg_o      (cfg)
  );

  // projection
  logic                 pj_valid, pj_ready, disc_in;
  logic signed [PW-1:0] ra, rp, ea, ep;

  swbt_proj #(.COORD_WIDTH(COORD_WIDTH), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_proj (
    .clk_i, .rst_ni,
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .rx_i        (item_i.receiver_x),
    .ry_i        (item_i.receiver_y),
    .ex_i        (item_i.emitter_pos_x),
    .ey_i        (item_i.emitter_pos_y),
    .cx_i        (center_x),
    .cy_i        (center_y),
    .cfg_i       (cfg),
    .out_valid_o (pj_valid),
    .out_ready_i (pj_ready),
    .ra_o        (ra),
    .rp_o        (rp),
    .ea_o        (ea),
    .ep_o        (ep),
    .disc_in_o   (disc_in)
  );

  // classify
  logic                    cl_valid, cl_ready;
  logic signed [SlabW-1:0] lo_a, hi_a, den_a, lo_p, hi_p, den_p;
  flags_t                  flags;

  swbt_clas #(.COORD_WIDTH(COORD_WIDTH), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_clas (
    .clk_i, .rst_ni,
    .in_valid_i  (pj_valid),
    .in_ready_o  (pj_ready),
    .ra_i        (ra),
    .rp_i        (rp),
    .ea_i        (ea),
    .ep_i        (ep),
    .disc_in_i   (disc_in),
    .cfg_i       (cfg),
    .out_valid_o (cl_valid),
    .out_ready_i (cl_ready),
    .lo_a_o      (lo_a),
    .hi_a_o      (hi_a),
    .den_a_o     (den_a),
    .lo_p_o      (lo_p),
    .hi_p_o      (hi_p),
    .den_p_o     (den_p),
    .flags_o     (flags)
  );

  // slab compare and result register
  swbt_slab #(.COORD_WIDTH(COORD_WIDTH), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_slab (
    .clk_i, .rst_ni,
    .in_valid_i  (cl_valid),
    .in_ready_o  (cl_ready),
    .lo_a_i      (lo_a),
    .hi_a_i      (hi_a),
    .den_a_i     (den_a),
    .lo_p_i      (lo_p),
    .hi_p_i      (hi_p),
    .den_p_i     (den_p),
    .flags_i     (flags),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .blocked_o   (result_o.blocked),
    .hit_kind_o  (result_o.hit_kind)
  );

endmodule
